>>> rtl/dsfm_pkg.sv
// Package for the drive status frame monitor.
// Holds widths, CAN function codes, register indexes and shared types.
// No dependencies.
`default_nettype none

package dsfm_pkg;

    // Field widths
    localparam int ID_W   = 11;
    localparam int NODE_W = 7;
    localparam int WORD_W = 16;
    localparam int SLOT_W = 2;
    localparam int KIND_W = 2;
    localparam int USE_W  = 4;

    // Steering table
    localparam int MAX_SLOTS       = 4;
    localparam int STEER_SLOTS_DEF = 4;

    // CAN identifier decode
    localparam logic [ID_W-1:0] FUNC_MASK   = 11'h780;
    localparam logic [ID_W-1:0] NODE_MASK   = 11'h07F;
    localparam logic [ID_W-1:0] FUNC_STATUS = 11'h180;
    localparam logic [ID_W-1:0] FUNC_ERROR  = 11'h280;

    // Status word bit positions
    localparam int SW_ENABLE = 2;
    localparam int SW_FAULT  = 3;
    localparam int SW_REACH  = 10;
    localparam int SW_LIMIT  = 11;

    // Fault kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MINOR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FATAL  = 2'd2;

    // APB register map
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IW  = 3;
    localparam logic [REG_IW-1:0] REG_NODE_A = 3'd0;
    localparam logic [REG_IW-1:0] REG_NODE_B = 3'd1;
    localparam logic [REG_IW-1:0] REG_NODE_C = 3'd2;
    localparam logic [REG_IW-1:0] REG_NODE_D = 3'd3;
    localparam logic [REG_IW-1:0] REG_IN_USE = 3'd4;
    localparam logic [REG_IW-1:0] REG_FATAL  = 3'd5;
    localparam logic [REG_IW-1:0] REG_MINOR  = 3'd6;

    // One slot of drive state
    typedef struct packed {
        logic [WORD_W-1:0] status;
        logic [WORD_W-1:0] error;
        logic              enable;
        logic              reach;
        logic              limit;
        logic              fault;
    } t_entry;

    // Steering table lookup result
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_match;

    // Fault masks handed to the update logic
    typedef struct packed {
        logic [WORD_W-1:0] fatal;
        logic [WORD_W-1:0] minor;
    } t_masks;

    // Fault notification of one request
    typedef struct packed {
        logic              report;
        logic [KIND_W-1:0] kind;
        logic              stop;
    } t_flags;

endpackage

`default_nettype wire

>>> rtl/dsfm_if.sv
// Valid/ready channel interfaces for the frame input and the result output.
// Depends on dsfm_pkg.
`default_nettype none

interface dsfm_in_if
    import dsfm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [WORD_W-1:0] payload_word;

    modport source (output valid, output frame_id, output payload_word, input ready);
    modport sink   (input valid, input frame_id, input payload_word, output ready);
endinterface

interface dsfm_out_if
    import dsfm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_number;
    logic [SLOT_W-1:0] slot_index;
    logic              report_fault;
    logic [KIND_W-1:0] fault_kind;
    logic              stop_request;
    logic              drive_enabled;
    logic              target_reached;
    logic              internal_limit;
    logic              fault_flag;
    logic [WORD_W-1:0] status_value;
    logic [WORD_W-1:0] error_value;

    modport source (
        output valid, output node_number, output slot_index, output report_fault,
        output fault_kind, output stop_request, output drive_enabled,
        output target_reached, output internal_limit, output fault_flag,
        output status_value, output error_value, input ready
    );
    modport sink (
        input valid, input node_number, input slot_index, input report_fault,
        input fault_kind, input stop_request, input drive_enabled,
        input target_reached, input internal_limit, input fault_flag,
        input status_value, input error_value, output ready
    );
endinterface

`default_nettype wire

>>> rtl/dsfm_regs.sv
// APB configuration registers and steering table node lookup.
// Depends on dsfm_pkg.
`default_nettype none

module dsfm_regs
    import dsfm_pkg::*;
#(
    parameter int STEER_SLOTS = STEER_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic [NODE_W-1:0] i_node,
    output t_match                 o_match,
    output t_masks                 o_masks
);

    logic [NODE_W-1:0] r_node [MAX_SLOTS];
    logic [USE_W-1:0]  r_in_use;
    logic [WORD_W-1:0] r_fatal;
    logic [WORD_W-1:0] r_minor;
    logic [REG_IW-1:0] reg_idx;
    logic              wr_req;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_req  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_node[i] <= '0;
            end
            r_in_use <= '0;
            r_fatal  <= '0;
            r_minor  <= '0;
        end else if (wr_req) begin
            unique case (reg_idx)
                REG_NODE_A: r_node[0] <= pwdata[NODE_W-1:0];
                REG_NODE_B: r_node[1] <= pwdata[NODE_W-1:0];
                REG_NODE_C: r_node[2] <= pwdata[NODE_W-1:0];
                REG_NODE_D: r_node[3] <= pwdata[NODE_W-1:0];
                REG_IN_USE: r_in_use  <= pwdata[USE_W-1:0];
                REG_FATAL:  r_fatal   <= pwdata[WORD_W-1:0];
                REG_MINOR:  r_minor   <= pwdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_NODE_A: prdata = APB_DW'(r_node[0]);
            REG_NODE_B: prdata = APB_DW'(r_node[1]);
            REG_NODE_C: prdata = APB_DW'(r_node[2]);
            REG_NODE_D: prdata = APB_DW'(r_node[3]);
            REG_IN_USE: prdata = APB_DW'(r_in_use);
            REG_FATAL:  prdata = APB_DW'(r_fatal);
            REG_MINOR:  prdata = APB_DW'(r_minor);
            default:    prdata = '0;
        endcase
    end

    // Lowest registered slot whose node number matches wins
    always_comb begin
        o_match = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (i < STEER_SLOTS && r_in_use[i] && r_node[i] == i_node) begin
                o_match.hit  = 1'b1;
                o_match.slot = SLOT_W'(i);
            end
        end
    end

    assign o_masks.fatal = r_fatal;
    assign o_masks.minor = r_minor;

endmodule

`default_nettype wire

>>> rtl/dsfm_ram.sv
// Per-slot drive state memory: one write port, one registered read port.
// Entries read as zero until first written. Depends on dsfm_pkg.
`default_nettype none

module dsfm_ram
    import dsfm_pkg::*;
#(
    parameter int STEER_SLOTS = STEER_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_slot,
    input  wire logic              i_wr_en,
    input  wire logic [SLOT_W-1:0] i_wr_slot,
    input  wire t_entry            i_wr_data,
    output t_entry                 o_rd_data
);

    localparam int AW = (STEER_SLOTS > 1) ? $clog2(STEER_SLOTS) : 1;

    t_entry                 r_mem [STEER_SLOTS];
    logic [STEER_SLOTS-1:0] r_vld;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;

    assign rd_addr = i_rd_slot[AW-1:0];
    assign wr_addr = i_wr_slot[AW-1:0];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
    end

    // Written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // Read port, held while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr] && !(i_rst_n == 1'b0);
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> rtl/dsfm_upd.sv
// Read-modify-write update of one slot for a status or an error frame.
// Pure combinational. Depends on dsfm_pkg.
`default_nettype none

module dsfm_upd
    import dsfm_pkg::*;
(
    input  wire t_entry            i_old,
    input  wire logic              i_is_status,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire t_masks            i_masks,
    output t_entry                 o_new,
    output t_flags                 o_flags
);

    logic fatal_hit;
    logic minor_hit;

    assign fatal_hit = |(i_word & i_masks.fatal);
    assign minor_hit = |(i_word & i_masks.minor);

    always_comb begin
        o_new   = i_old;
        o_flags = '0;
        if (i_is_status) begin
            // Status word: store, decode bits, report fault rising edge
            o_new.status = i_word;
            o_new.enable = i_word[SW_ENABLE];
            o_new.reach  = i_word[SW_REACH];
            o_new.limit  = i_word[SW_LIMIT];
            o_new.fault  = i_word[SW_FAULT];
            o_flags.report = !i_old.fault && i_word[SW_FAULT];
            o_flags.kind   = KIND_STATUS;
        end else begin
            // Error word: fatal beats minor, a clean word clears fault
            o_new.error = i_word;
            if (fatal_hit) begin
                o_new.fault    = 1'b1;
                o_flags.report = 1'b1;
                o_flags.kind   = KIND_FATAL;
                o_flags.stop   = 1'b1;
            end else if (minor_hit) begin
                o_new.fault    = 1'b1;
                o_flags.report = 1'b1;
                o_flags.kind   = KIND_MINOR;
            end else begin
                o_new.fault = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/drive_status_frame_monitor_unit.sv
// Top level of the drive status frame monitor.
// Depends on dsfm_pkg, dsfm_if, dsfm_regs, dsfm_ram, dsfm_upd.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------------
//  i_in     | in  | valid/ready       | frame_id, payload_word
//  o_out    | out | valid/ready       | node, slot, fault flags, stored words
//  APB      | in  | psel/penable      | 7 registers at 4*i, pready tied high
//
// One request per cycle sustained while the output does not stall. The input
// stage looks up the node and reads the slot memory; the update stage updates and
// writes back (the last write is forwarded) and loads the output register.
// Frames of unregistered nodes or other functions are taken and dropped.
// Output stalls hold the update stage, which holds the input side.
// Reset (synchronous, active low) clears the control and configuration registers and the memory's written flags.
`default_nettype none

module drive_status_frame_monitor_unit
    import dsfm_pkg::*;
#(
    parameter int STEER_SLOTS = STEER_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    dsfm_in_if.sink                i_in,
    dsfm_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_match            match;
    t_masks            masks;
    logic [NODE_W-1:0] in_node;
    logic [ID_W-1:0]   in_func;
    logic              in_keep;
    logic              in_take;
    logic              s1_adv;

    logic              r_s1_vld;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [NODE_W-1:0] r_s1_node;
    logic              r_s1_status;
    logic [WORD_W-1:0] r_s1_word;

    logic              r_fwd_vld;
    logic [SLOT_W-1:0] r_fwd_slot;
    t_entry            r_fwd_data;

    t_entry            rd_data;
    t_entry            old_entry;
    t_entry            new_entry;
    t_flags            flags;

    logic              r_out_vld;
    logic [NODE_W-1:0] r_out_node;
    logic [SLOT_W-1:0] r_out_slot;
    t_flags            r_out_flags;
    t_entry            r_out_entry;

    // Configuration and node lookup
    dsfm_regs #(
        .STEER_SLOTS(STEER_SLOTS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_node  (in_node),
        .o_match (match),
        .o_masks (masks)
    );

    // Request decode
    assign in_node = i_in.frame_id[NODE_W-1:0];
    assign in_func = i_in.frame_id & FUNC_MASK;
    assign in_keep = match.hit && (in_func == FUNC_STATUS || in_func == FUNC_ERROR);

    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_take    = i_in.valid && i_in.ready && in_keep;

    // Slot state memory
    dsfm_ram #(
        .STEER_SLOTS(STEER_SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_take),
        .i_rd_slot (match.slot),
        .i_wr_en   (s1_adv),
        .i_wr_slot (r_s1_slot),
        .i_wr_data (new_entry),
        .o_rd_data (rd_data)
    );

    // Update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= in_take;
        end
    end

    // Update stage payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_slot   <= match.slot;
            r_s1_node   <= in_node;
            r_s1_status <= (in_func == FUNC_STATUS);
            r_s1_word   <= i_in.payload_word;
        end
    end

    // Last write kept for forwarding over the memory's read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (s1_adv) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_fwd_slot <= r_s1_slot;
            r_fwd_data <= new_entry;
        end
    end

    assign old_entry = (r_fwd_vld && r_fwd_slot == r_s1_slot) ? r_fwd_data : rd_data;

    dsfm_upd u_upd (
        .i_old       (old_entry),
        .i_is_status (r_s1_status),
        .i_word      (r_s1_word),
        .i_masks     (masks),
        .o_new       (new_entry),
        .o_flags     (flags)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_node  <= r_s1_node;
            r_out_slot  <= r_s1_slot;
            r_out_flags <= flags;
            r_out_entry <= new_entry;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.node_number    = r_out_node;
    assign o_out.slot_index     = r_out_slot;
    assign o_out.report_fault   = r_out_flags.report;
    assign o_out.fault_kind     = r_out_flags.kind;
    assign o_out.stop_request   = r_out_flags.stop;
    assign o_out.drive_enabled  = r_out_entry.enable;
    assign o_out.target_reached = r_out_entry.reach;
    assign o_out.internal_limit = r_out_entry.limit;
    assign o_out.fault_flag     = r_out_entry.fault;
    assign o_out.status_value   = r_out_entry.status;
    assign o_out.error_value    = r_out_entry.error;

endmodule

`default_nettype wire

>>> rtl/dsfm_chk.sv
// Port-level checks of the drive status frame monitor, bound to the top level.
// Depends on dsfm_pkg.
`default_nettype none

module dsfm_chk
    import dsfm_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_report,
    input wire logic [KIND_W-1:0] i_kind,
    input wire logic              i_stop,
    input wire logic              i_fault,
    input wire logic [WORD_W-1:0] i_status
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("result dropped or changed under stall");

    // Any reported fault leaves the slot faulted
    a_report_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_report |-> i_fault)
        else $error("fault reported but fault flag clear");

    // Emergency stop only with a reported fatal error
    a_stop_fatal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stop |-> i_report && i_kind == KIND_FATAL)
        else $error("stop request without fatal report");

    // Kind is zero when nothing is reported
    a_kind_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_report |-> i_kind == KIND_STATUS)
        else $error("fault kind set without report");

endmodule

bind drive_status_frame_monitor_unit dsfm_chk u_dsfm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_report    (o_out.report_fault),
    .i_kind      (o_out.fault_kind),
    .i_stop      (o_out.stop_request),
    .i_fault     (o_out.fault_flag),
    .i_status    (o_out.status_value)
);

`default_nettype wire
